// ----- hw/rtl/gbcs_pkg.sv -----
// Shared constants, sequencer types and microcode table for the gyro bias block.
package gbcs_pkg;

  localparam int NUM_SENSORS = 64;
  localparam int GYRO_AXES   = 3;
  localparam int STORE_DEPTH = NUM_SENSORS * GYRO_AXES;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int SUM_W       = 24;
  localparam int SAMPLE_W    = 16;
  localparam int SENSOR_W    = 6;
  localparam int AXIS_W      = 3;
  localparam int FRAMES_W    = 8;
  localparam int FIELDS_W    = SENSOR_W + AXIS_W + SAMPLE_W;
  localparam int TDATA_W     = ((FIELDS_W + 7) / 8) * 8;
  localparam int PAD_W       = TDATA_W - FIELDS_W;
  localparam int DIV_STEPS   = SUM_W;
  localparam int DIV_CNT_W   = $clog2(DIV_STEPS + 1);

  localparam logic [FRAMES_W-1:0] CALIB_RESET     = 8'd200;
  localparam logic [AXIS_W-1:0]   AXIS_GYRO_FIRST = 3'd3;
  localparam logic [AXIS_W-1:0]   AXIS_GYRO_LAST  = 3'd5;
  localparam logic                OP_START        = 1'b1;

  typedef enum logic [3:0] {
    S_FETCH    = 4'd0,
    S_START    = 4'd1,
    S_DISPATCH = 4'd2,
    S_ACCUM    = 4'd3,
    S_OUT      = 4'd4,
    S_WINIT    = 4'd5,
    S_WREAD    = 4'd6,
    S_DSTART   = 4'd7,
    S_DWAIT    = 4'd8,
    S_WRITE    = 4'd9,
    S_DONE     = 4'd10
  } step_t;

  typedef enum logic [2:0] {
    COND_ALWAYS,
    COND_ACCEPT,
    COND_START,
    COND_CALIB,
    COND_FINISH,
    COND_DIV_BUSY,
    COND_MORE,
    COND_OUT_FREE
  } cond_t;

  typedef enum logic [3:0] {
    ACT_NONE,
    ACT_FETCH,
    ACT_START,
    ACT_ACCUM,
    ACT_EMIT,
    ACT_WALK_INIT,
    ACT_WALK_READ,
    ACT_DIV_START,
    ACT_WRITE_Q,
    ACT_FINISH
  } act_t;

  typedef struct packed {
    act_t  act;
    cond_t cond;
    step_t tgt;
    step_t nxt;
  } ucode_t;

  // cond true -> tgt, else nxt
  function automatic ucode_t ucode(step_t s);
    ucode_t w;
    unique case (s)
      S_FETCH:    w = '{ACT_FETCH,     COND_ACCEPT,   S_START,    S_FETCH};
      S_START:    w = '{ACT_START,     COND_START,    S_FETCH,    S_DISPATCH};
      S_DISPATCH: w = '{ACT_NONE,      COND_CALIB,    S_ACCUM,    S_OUT};
      S_ACCUM:    w = '{ACT_ACCUM,     COND_FINISH,   S_WINIT,    S_FETCH};
      S_OUT:      w = '{ACT_EMIT,      COND_OUT_FREE, S_FETCH,    S_OUT};
      S_WINIT:    w = '{ACT_WALK_INIT, COND_ALWAYS,   S_WREAD,    S_WREAD};
      S_WREAD:    w = '{ACT_WALK_READ, COND_ALWAYS,   S_DSTART,   S_DSTART};
      S_DSTART:   w = '{ACT_DIV_START, COND_ALWAYS,   S_DWAIT,    S_DWAIT};
      S_DWAIT:    w = '{ACT_NONE,      COND_DIV_BUSY, S_DWAIT,    S_WRITE};
      S_WRITE:    w = '{ACT_WRITE_Q,   COND_MORE,     S_WREAD,    S_DONE};
      S_DONE:     w = '{ACT_FINISH,    COND_ALWAYS,   S_FETCH,    S_FETCH};
      default:    w = '{ACT_NONE,      COND_ALWAYS,   S_FETCH,    S_FETCH};
    endcase
    return w;
  endfunction

endpackage

// ----- hw/rtl/gyro_bias_calibrate_subtract.sv -----
// Top level: microcoded gyro bias calibration and subtraction for a sensor array.
//
// Input stream s_axis carries one sensor element per item; tuser = 1 starts a
// calibration (clears the bias store), tlast marks a frame's last element.
// Output stream m_axis gives one corrected element per normal-mode sample;
// nothing is emitted for start items or while calibrating.
// cfg_valid/cfg_data write calib_frames (frames averaged); cfg_ready is always high.
// The microcode sequencer steps one control word per cycle: a start item runs
// fetch and start; a calibration or normal sample runs fetch, start, dispatch and
// then accumulate or emit; a normal result enters the output register in emit.
// After the last calibration frame a finalize walk runs over all 192 store
// entries, each read, divided by a 1-bit-per-cycle restoring divider and
// written back; no item is accepted during the walk.
// Reset clears mode, frame count, output valid and the per-entry valid bits
// (an unwritten entry reads as zero); calib_frames returns to 200.
// The output register lets the next item be accepted while a result waits;
// a stalled receiver holds the sequencer in its emit step until the
// register frees.
module gyro_bias_calibrate_subtract (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // [5:0] sensor, [8:6] axis, [24:9] sample, rest zero
  input  logic [gbcs_pkg::TDATA_W-1:0]  s_axis_tdata,
  // [0] operation
  input  logic                          s_axis_tuser,
  input  logic                          s_axis_tlast,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [5:0] out_sensor, [8:6] out_axis, [24:9] corrected, rest zero
  output logic [gbcs_pkg::TDATA_W-1:0]  m_axis_tdata,
  output logic                          m_axis_tlast,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [gbcs_pkg::FRAMES_W-1:0] cfg_data
);

  localparam int SW = gbcs_pkg::SENSOR_W;
  localparam int AW = gbcs_pkg::AXIS_W;
  localparam int DW = gbcs_pkg::SAMPLE_W;
  localparam int NW = gbcs_pkg::SUM_W;
  localparam int XW = gbcs_pkg::ADDR_W;
  localparam int FW = gbcs_pkg::FRAMES_W;

  gbcs_pkg::step_t  pc, pc_next;
  gbcs_pkg::ucode_t uc;
  logic             cond_true;

  logic [FW-1:0] calib_frames;
  logic          calibrating;
  logic          calibrated;
  logic [FW-1:0] frame_count;
  logic [FW-1:0] fc_inc;

  // incoming item fields
  logic [SW-1:0]        in_sensor;
  logic [AW-1:0]        in_axis;
  logic signed [DW-1:0] in_sample;
  logic                 in_gyro;
  logic [XW-1:0]        in_idx;
  logic                 in_acc;

  // latched item
  logic                 it_op;
  logic [SW-1:0]        it_sensor;
  logic [AW-1:0]        it_axis;
  logic signed [DW-1:0] it_sample;
  logic                 it_last;
  logic                 it_gyro;
  logic [XW-1:0]        it_idx;

  // bias store
  logic [NW-1:0]                    store [gbcs_pkg::STORE_DEPTH];
  logic [gbcs_pkg::STORE_DEPTH-1:0] valid;
  logic                             rd_en, wr_en;
  logic [XW-1:0]                    rd_addr, wr_addr;
  logic [NW-1:0]                    wr_data;
  logic [NW-1:0]                    rd_data;
  logic                             rd_valid;
  logic [NW-1:0]                    bias_rd;
  logic [NW-1:0]                    sum;

  // finalize walk and divider
  logic [XW-1:0]                    walk_addr;
  logic [FW-1:0]                    divisor;
  logic [FW-1:0]                    div_rem;
  logic [NW-1:0]                    div_quo;
  logic                             div_neg;
  logic [gbcs_pkg::DIV_CNT_W-1:0]   div_cnt;
  logic [FW:0]                      trial;
  logic                             trial_ge;
  logic [NW-1:0]                    quotient;

  logic                             out_free;
  logic [DW-1:0]                    corrected;

  assign in_sensor = s_axis_tdata[SW-1:0];
  assign in_axis   = s_axis_tdata[SW+AW-1:SW];
  assign in_sample = s_axis_tdata[SW+AW+DW-1:SW+AW];
  assign in_gyro   = (in_axis >= gbcs_pkg::AXIS_GYRO_FIRST) &&
                     (in_axis <= gbcs_pkg::AXIS_GYRO_LAST) &&
                     (int'(in_sensor) < gbcs_pkg::NUM_SENSORS);
  assign in_idx    = XW'(in_sensor) * XW'(gbcs_pkg::GYRO_AXES) +
                     XW'(in_axis - gbcs_pkg::AXIS_GYRO_FIRST);
  assign in_acc    = s_axis_tvalid && s_axis_tready;

  assign cfg_ready = 1'b1;
  assign fc_inc    = frame_count + FW'(1);
  assign out_free  = !m_axis_tvalid || m_axis_tready;

  // sequencer
  assign uc = gbcs_pkg::ucode(pc);

  always_comb begin
    unique case (uc.cond)
      gbcs_pkg::COND_ALWAYS:   cond_true = 1'b1;
      gbcs_pkg::COND_ACCEPT:   cond_true = in_acc;
      gbcs_pkg::COND_START:    cond_true = (it_op == gbcs_pkg::OP_START);
      gbcs_pkg::COND_CALIB:    cond_true = calibrating;
      gbcs_pkg::COND_FINISH:   cond_true = it_last && (fc_inc >= calib_frames);
      gbcs_pkg::COND_DIV_BUSY: cond_true = (div_cnt != '0);
      gbcs_pkg::COND_MORE:     cond_true = (walk_addr != XW'(gbcs_pkg::STORE_DEPTH - 1));
      gbcs_pkg::COND_OUT_FREE: cond_true = out_free;
      default:                 cond_true = 1'b1;
    endcase
  end

  always_comb begin
    pc_next = cond_true ? uc.tgt : uc.nxt;
  end

  always_comb begin
    s_axis_tready = (uc.act == gbcs_pkg::ACT_FETCH);
  end

  // store access
  assign bias_rd  = rd_valid ? rd_data : '0;
  assign sum      = bias_rd + {{(NW-DW){it_sample[DW-1]}}, it_sample};
  assign quotient = div_neg ? (~div_quo + NW'(1)) : div_quo;

  always_comb begin
    rd_en   = (uc.act == gbcs_pkg::ACT_FETCH) || (uc.act == gbcs_pkg::ACT_WALK_READ);
    rd_addr = (uc.act == gbcs_pkg::ACT_FETCH) ? in_idx : walk_addr;
    wr_en   = ((uc.act == gbcs_pkg::ACT_ACCUM) && it_gyro) ||
              (uc.act == gbcs_pkg::ACT_WRITE_Q);
    wr_addr = (uc.act == gbcs_pkg::ACT_WRITE_Q) ? walk_addr : it_idx;
    wr_data = (uc.act == gbcs_pkg::ACT_WRITE_Q) ? quotient : sum;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      store[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data  <= store[rd_addr];
      rd_valid <= valid[rd_addr];
    end
  end

  // divider step
  assign trial    = {div_rem, div_quo[NW-1]};
  assign trial_ge = (trial >= {1'b0, divisor});

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      pc            <= gbcs_pkg::S_FETCH;
      calib_frames  <= gbcs_pkg::CALIB_RESET;
      calibrating   <= 1'b0;
      calibrated    <= 1'b0;
      frame_count   <= '0;
      valid         <= '0;
      div_cnt       <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      pc <= pc_next;
      if (cfg_valid && cfg_ready) begin
        calib_frames <= cfg_data;
      end
      if (uc.act == gbcs_pkg::ACT_START && it_op == gbcs_pkg::OP_START) begin
        calibrating <= 1'b1;
        frame_count <= '0;
        valid       <= '0;
      end
      if (uc.act == gbcs_pkg::ACT_ACCUM) begin
        if (it_gyro) begin
          valid[it_idx] <= 1'b1;
        end
        if (it_last) begin
          frame_count <= fc_inc;
        end
      end
      if (uc.act == gbcs_pkg::ACT_WRITE_Q) begin
        valid[walk_addr] <= 1'b1;
      end
      if (uc.act == gbcs_pkg::ACT_FINISH) begin
        calibrated  <= 1'b1;
        calibrating <= 1'b0;
      end
      if (uc.act == gbcs_pkg::ACT_DIV_START) begin
        div_cnt <= gbcs_pkg::DIV_CNT_W'(gbcs_pkg::DIV_STEPS);
      end else if (div_cnt != '0) begin
        div_cnt <= div_cnt - gbcs_pkg::DIV_CNT_W'(1);
      end
      if (uc.act == gbcs_pkg::ACT_EMIT && out_free) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  // payload
  assign corrected = (calibrated && it_gyro) ? (it_sample - bias_rd[DW-1:0]) : it_sample;

  always_ff @(posedge clk) begin
    if (in_acc) begin
      it_op     <= s_axis_tuser;
      it_sensor <= in_sensor;
      it_axis   <= in_axis;
      it_sample <= in_sample;
      it_last   <= s_axis_tlast;
      it_gyro   <= in_gyro;
      it_idx    <= in_idx;
    end
    if (uc.act == gbcs_pkg::ACT_WALK_INIT) begin
      walk_addr <= '0;
      divisor   <= (frame_count == '0) ? FW'(1) : frame_count;
    end else if (uc.act == gbcs_pkg::ACT_WRITE_Q) begin
      walk_addr <= walk_addr + XW'(1);
    end
    if (uc.act == gbcs_pkg::ACT_DIV_START) begin
      div_neg <= bias_rd[NW-1];
      div_quo <= bias_rd[NW-1] ? (~bias_rd + NW'(1)) : bias_rd;
      div_rem <= '0;
    end else if (div_cnt != '0) begin
      div_rem <= trial_ge ? FW'(trial - {1'b0, divisor}) : trial[FW-1:0];
      div_quo <= {div_quo[NW-2:0], trial_ge};
    end
    if (uc.act == gbcs_pkg::ACT_EMIT && out_free) begin
      m_axis_tdata <= {{gbcs_pkg::PAD_W{1'b0}}, corrected, it_axis, it_sensor};
      m_axis_tlast <= it_last;
    end
  end

  a_walk_in_range: assert property (@(posedge clk) disable iff (rst)
    pc == gbcs_pkg::S_WRITE |-> walk_addr <= XW'(gbcs_pkg::STORE_DEPTH - 1))
    else $error("finalize walk past end of store");

  a_div_loaded: assert property (@(posedge clk) disable iff (rst)
    pc == gbcs_pkg::S_DSTART |=> div_cnt == gbcs_pkg::DIV_CNT_W'(gbcs_pkg::DIV_STEPS))
    else $error("divider not loaded");

  a_divisor_nonzero: assert property (@(posedge clk) disable iff (rst)
    pc == gbcs_pkg::S_DWAIT |-> divisor != '0)
    else $error("zero divisor in finalize");

  a_no_emit_calib: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> !calibrating)
    else $error("item emitted while calibrating");

  a_calibrated_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(calibrated) |-> $past(pc) == gbcs_pkg::S_DONE)
    else $error("calibrated set outside finalize");

endmodule

// ----- dv/gyro_bias_calibrate_subtract_tb.sv -----
// Self-checking testbench for the gyro bias calibration and subtraction block.
module gyro_bias_calibrate_subtract_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SENSOR_W    = gbcs_pkg::SENSOR_W;
  localparam int AXIS_W      = gbcs_pkg::AXIS_W;
  localparam int SAMPLE_W    = gbcs_pkg::SAMPLE_W;
  localparam int TDATA_W     = gbcs_pkg::TDATA_W;
  localparam int FRAMES_W    = gbcs_pkg::FRAMES_W;
  localparam int SUM_W       = gbcs_pkg::SUM_W;
  localparam int STORE_DEPTH = gbcs_pkg::STORE_DEPTH;
  localparam int NUM_SENSORS = gbcs_pkg::NUM_SENSORS;
  localparam int GYRO_AXES   = gbcs_pkg::GYRO_AXES;

  localparam logic [FRAMES_W-1:0] CALIB_RESET     = gbcs_pkg::CALIB_RESET;
  localparam logic [AXIS_W-1:0]   AXIS_GYRO_FIRST = gbcs_pkg::AXIS_GYRO_FIRST;
  localparam logic [AXIS_W-1:0]   AXIS_GYRO_LAST  = gbcs_pkg::AXIS_GYRO_LAST;
  localparam logic                OP_START        = gbcs_pkg::OP_START;

  localparam int AXIS_LSB       = SENSOR_W;
  localparam int VALUE_LSB      = SENSOR_W + AXIS_W;
  localparam int WATCHDOG_LIMIT = 40000;
  localparam int SETTLE_CYCLES  = 32;
  localparam int WALK_CYCLES    = 6000;
  localparam int RANDOM_ITEMS   = 1500;

  typedef struct packed {
    logic [SENSOR_W-1:0]        sensor;
    logic [AXIS_W-1:0]          axis;
    logic signed [SAMPLE_W-1:0] value;
    logic                       last;
  } elem_t;

  logic                clk;
  logic                rst;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [TDATA_W-1:0]  s_axis_tdata;
  logic                s_axis_tuser;
  logic                s_axis_tlast;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [TDATA_W-1:0]  m_axis_tdata;
  logic                m_axis_tlast;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [FRAMES_W-1:0] cfg_data;

  gyro_bias_calibrate_subtract u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data)
  );

  // bias predictor state
  logic signed [SUM_W-1:0] bias_sum [STORE_DEPTH];
  logic                    in_calib;
  logic                    have_bias;
  logic [FRAMES_W-1:0]     frames_seen;
  logic [FRAMES_W-1:0]     frames_needed;
  bit                      walk_pending;

  elem_t corrected_q[$];

  int  items_sent;
  int  results_checked;
  int  mismatches;
  int  calibrations_done;
  int  quiet_cycles;
  int  hold_cycles;
  bit  tx_gaps;
  bit  rx_stalls;

  initial clk = 1'b0;
  always #2 clk = ~clk;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic void reset_bias_model();
    foreach (bias_sum[i]) bias_sum[i] = '0;
    in_calib      = 1'b0;
    have_bias     = 1'b0;
    frames_seen   = '0;
    frames_needed = CALIB_RESET;
    walk_pending  = 1'b0;
  endfunction

  function automatic void average_biases();
    int n;
    int q;
    n = (frames_seen < 1) ? 1 : int'(frames_seen);
    foreach (bias_sum[i]) begin
      q = int'(bias_sum[i]) / n;
      bias_sum[i] = q[SUM_W-1:0];
    end
    have_bias    = 1'b1;
    in_calib     = 1'b0;
    walk_pending = 1'b1;
    calibrations_done++;
  endfunction

  function automatic void predict_element(input logic op, input logic [SENSOR_W-1:0] sensor,
                                          input logic [AXIS_W-1:0] axis,
                                          input logic signed [SAMPLE_W-1:0] sample,
                                          input logic last);
    bit    gyro;
    int    idx;
    elem_t e;
    gyro = (axis >= AXIS_GYRO_FIRST) && (axis <= AXIS_GYRO_LAST) && (sensor < NUM_SENSORS);
    idx  = gyro ? int'(sensor) * GYRO_AXES + int'(axis - AXIS_GYRO_FIRST) : 0;
    if (op == OP_START) begin
      foreach (bias_sum[i]) bias_sum[i] = '0;
      in_calib    = 1'b1;
      frames_seen = '0;
    end else if (in_calib) begin
      if (gyro) bias_sum[idx] = bias_sum[idx] + sample;
      if (last) begin
        frames_seen = frames_seen + 1'b1;
        if (frames_seen >= frames_needed) average_biases();
      end
    end else begin
      e.sensor = sensor;
      e.axis   = axis;
      e.value  = (have_bias && gyro) ? SAMPLE_W'(sample - bias_sum[idx]) : sample;
      e.last   = last;
      corrected_q.push_back(e);
    end
  endfunction

  task automatic send_item(input logic op, input logic [SENSOR_W-1:0] sensor,
                           input logic [AXIS_W-1:0] axis,
                           input logic signed [SAMPLE_W-1:0] sample, input logic last);
    int gap;
    gap = tx_gaps ? pick_gap() : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= TDATA_W'({sample, axis, sensor});
    s_axis_tlast  <= last;
    do @(posedge clk); while (!s_axis_tready);
    predict_element(op, sensor, axis, sample, last);
    items_sent++;
  endtask

  task automatic send_start();
    send_item(OP_START, SENSOR_W'($urandom), AXIS_W'($urandom), SAMPLE_W'($urandom),
              1'($urandom));
  endtask

  // drain results, then let the block finish its current work
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (corrected_q.size() != 0) @(posedge clk);
    repeat (walk_pending ? WALK_CYCLES : SETTLE_CYCLES) @(posedge clk);
    walk_pending = 1'b0;
  endtask

  task automatic write_calib_frames(input logic [FRAMES_W-1:0] frames);
    cfg_valid <= 1'b1;
    cfg_data  <= frames;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid     <= 1'b0;
    frames_needed = frames;
  endtask

  task automatic normal_burst(input int count);
    logic [SENSOR_W-1:0] sensor;
    logic                op;
    for (int k = 0; k < count; k++) begin
      sensor = $urandom_range(0, 1) ? SENSOR_W'($urandom_range(0, 7)) : SENSOR_W'($urandom);
      op     = ($urandom_range(0, 199) == 0) ? OP_START : ~OP_START;
      send_item(op, sensor, AXIS_W'($urandom_range(0, 7)), SAMPLE_W'($urandom),
                $urandom_range(0, 3) == 0);
    end
  endtask

  task automatic calibrate_run(input logic [FRAMES_W-1:0] frames, input int max_len,
                               input int sensor_hi);
    int                  len;
    logic [AXIS_W-1:0]   axis;
    settle();
    write_calib_frames(frames);
    send_start();
    while (in_calib) begin
      len = $urandom_range(1, max_len);
      for (int k = 0; k < len; k++) begin
        axis = ($urandom_range(0, 9) < 7) ? AXIS_W'($urandom_range(3, 5))
                                          : AXIS_W'($urandom_range(0, 7));
        send_item(~OP_START, SENSOR_W'($urandom_range(0, sensor_hi)), axis,
                  SAMPLE_W'($urandom), k == len - 1);
      end
    end
  endtask

  // one long frame on a single sensor and axis so that its sum wraps
  task automatic sum_wrap_run();
    logic [SENSOR_W-1:0] sensor;
    logic [AXIS_W-1:0]   axis;
    bit                  neg;
    int                  mag;
    sensor = SENSOR_W'($urandom);
    axis   = AXIS_W'($urandom_range(3, 5));
    neg    = $urandom_range(0, 1);
    settle();
    write_calib_frames(8'd1);
    send_start();
    for (int k = 0; k < 270; k++) begin
      mag = $urandom_range(32000, 32767);
      send_item(~OP_START, sensor, axis, SAMPLE_W'(neg ? -mag - 1 : mag), k == 269);
    end
    for (int k = 0; k < 6; k++)
      send_item(~OP_START, sensor, axis, SAMPLE_W'($urandom), 1'($urandom));
  endtask

  task automatic test_passthrough();
    send_item(~OP_START, 6'd0,  3'd0, -16'sd32768, 1'b0);
    send_item(~OP_START, 6'd63, 3'd7, 16'sd32767,  1'b1);
    send_item(~OP_START, 6'd42, 3'd6, 16'sd0,      1'b0);
    send_item(~OP_START, 6'd17, 3'd3, -16'sd1,     1'b1);
  endtask

  task automatic test_calibrate_basic();
    settle();
    write_calib_frames(8'd1);
    send_start();
    send_item(~OP_START, 6'd0,  3'd3, -16'sd32768, 1'b0);
    send_item(~OP_START, 6'd63, 3'd5, 16'sd32767,  1'b0);
    send_item(~OP_START, 6'd10, 3'd7, 16'sd555,    1'b0);
    send_item(~OP_START, 6'd0,  3'd3, -16'sd32767, 1'b1);
    send_item(~OP_START, 6'd0,  3'd3, 16'sd0,      1'b1);
    send_item(~OP_START, 6'd63, 3'd5, -16'sd32768, 1'b0);
  endtask

  task automatic test_restart();
    settle();
    write_calib_frames(8'd3);
    send_start();
    send_item(~OP_START, 6'd1, 3'd3, 16'sd300, 1'b1);
    send_start();
    send_item(~OP_START, 6'd1, 3'd3, 16'sd7,   1'b1);
    send_item(~OP_START, 6'd1, 3'd4, -16'sd7,  1'b1);
    send_item(~OP_START, 6'd2, 3'd5, 16'sd9,   1'b1);
    send_item(~OP_START, 6'd1, 3'd4, 16'sd0,   1'b1);
  endtask

  task automatic test_frame_limits();
    settle();
    write_calib_frames(8'd0);
    send_start();
    send_item(~OP_START, 6'd3, 3'd3, 16'sd100, 1'b1);
    send_item(~OP_START, 6'd3, 3'd3, 16'sd100, 1'b0);
    settle();
    write_calib_frames(8'd255);
    send_start();
    for (int k = 0; k < 3; k++)
      send_item(~OP_START, 6'd4, 3'd4, SAMPLE_W'($urandom), 1'b1);
    // lowered below the frames already seen: ends at the next frame end
    settle();
    write_calib_frames(8'd2);
    send_item(~OP_START, 6'd4, 3'd4, SAMPLE_W'($urandom), 1'b1);
    send_item(~OP_START, 6'd4, 3'd4, 16'sd0, 1'b1);
  endtask

  task automatic test_backpressure();
    settle();
    tx_gaps     = 1'b0;
    hold_cycles = 400;
    normal_burst(30);
    settle();
    normal_burst(10);
    tx_gaps = 1'b1;
  endtask

  task automatic test_random();
    sum_wrap_run();
    calibrate_run(8'd255, 1, 63);
    while (items_sent < RANDOM_ITEMS) begin
      tx_gaps   = $urandom_range(0, 3) != 0;
      rx_stalls = $urandom_range(0, 3) != 0;
      if ($urandom_range(0, 9) < 2)
        calibrate_run(FRAMES_W'($urandom_range(1, 6)), 10, 7);
      else
        normal_burst($urandom_range(20, 80));
    end
  endtask

  // receiver: random stalls, plus long hold-offs on request
  initial begin : drive_ready
    int stall;
    m_axis_tready = 1'b0;
    forever begin
      if (hold_cycles > 0) begin
        m_axis_tready <= 1'b0;
        repeat (hold_cycles) @(posedge clk);
        hold_cycles = 0;
      end else begin
        stall = (rx_stalls && $urandom_range(0, 3) == 0) ? pick_gap() : 0;
        if (stall > 0) begin
          m_axis_tready <= 1'b0;
          repeat (stall) @(posedge clk);
        end else begin
          m_axis_tready <= 1'b1;
          @(posedge clk);
        end
      end
    end
  end

  always @(posedge clk) begin : check_results
    elem_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (corrected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected item: tdata %h tlast %b", m_axis_tdata, m_axis_tlast);
      end else begin
        want = corrected_q.pop_front();
        results_checked++;
        if (m_axis_tdata[SENSOR_W-1:0] !== want.sensor ||
            m_axis_tdata[AXIS_LSB +: AXIS_W] !== want.axis ||
            m_axis_tdata[VALUE_LSB +: SAMPLE_W] !== want.value ||
            m_axis_tlast !== want.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: sensor %0d/%0d axis %0d/%0d value %0d/%0d last %b/%b (exp/got)",
                     want.sensor, m_axis_tdata[SENSOR_W-1:0],
                     want.axis, m_axis_tdata[AXIS_LSB +: AXIS_W],
                     want.value, $signed(m_axis_tdata[VALUE_LSB +: SAMPLE_W]),
                     want.last, m_axis_tlast);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no item moved for %0d cycles", quiet_cycles);
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  initial begin
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    s_axis_tlast  = 1'b0;
    cfg_valid     = 1'b0;
    cfg_data      = '0;
    hold_cycles   = 0;
    tx_gaps       = 1'b1;
    rx_stalls     = 1'b1;
    reset_bias_model();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_passthrough();
    test_calibrate_basic();
    test_restart();
    test_frame_limits();
    test_backpressure();
    test_random();

    s_axis_tvalid <= 1'b0;
    while (corrected_q.size() != 0) @(posedge clk);
    repeat (64) @(posedge clk);
    if (corrected_q.size() != 0) mismatches++;

    $display("%0d items sent, %0d items checked, %0d calibrations completed, %0d mismatches",
             items_sent, results_checked, calibrations_done, mismatches);
    $display("covered calib_frames 0/1/255, restart, frame limit lowered, sum and bias wrap");
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hw/rtl/gbcs_pkg.sv
hw/rtl/gyro_bias_calibrate_subtract.sv
dv/gyro_bias_calibrate_subtract_tb.sv
